>>> rtl/sle_pkg.sv
// sle_pkg: shared widths, command and cell-mode codes, and the cell control bundle
// for the sequential list engine. No dependencies.
package sle_pkg;

   // number of list cells; the 5-bit length and position ports bound it
   localparam int DEPTH         = 16;
   localparam int DATA_W        = 32;
   localparam int LEN_W         = 5;

   localparam logic [LEN_W-1:0] CAP_RESET = 5'd10;

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_GET    = 2'd2;
   localparam logic [1:0] CMD_LOCATE = 2'd3;

   // what every cell does in a cycle
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_ROTATE = 2'd2;
   localparam logic [1:0] CELL_DROP   = 2'd3;

   typedef struct packed {
      logic [1:0]       mode;
      logic [LEN_W-1:0] mark;   // insert slot (position - 1)
      logic [LEN_W-1:0] span;   // occupied cells taking part
   } cell_ctl_type;

endpackage

>>> rtl/sequential_list_engine_core.sv
// sequential_list_engine_core: top level, command sequencer around a row of list cells.
// Depends on sle_pkg and sle_cell.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ------------------------------
//   request   req_command/position/item_value         start & !busy
//   result    rsp_ok/read_value/found_position/       rsp_valid, one cycle, no stall
//             rsp_entry_count
//   config    csr_capacity                            csr_valid & csr_ready
//
// Insert, and any command that fails its range check or meets an empty list, answers
// at once: the result beat shows the following cycle and busy never rises. Get, delete
// and locate on a non-empty list rotate the list once round the cells, one step per
// cycle, watching the head cell, with busy high while rotating. Reset clears the
// length and restores the capacity to 10; cell contents are left as they are. The result
// side cannot stall, so nothing waits on it.
module sequential_list_engine_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_command,
   input  logic [sle_pkg::LEN_W-1:0]            req_position,
   input  logic signed [sle_pkg::DATA_W-1:0]    req_item_value,
   // result
   output logic                                 rsp_valid,
   output logic                                 rsp_ok,
   output logic signed [sle_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [sle_pkg::LEN_W-1:0]            rsp_found_position,
   output logic [sle_pkg::LEN_W-1:0]            rsp_entry_count,
   // capacity register
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sle_pkg::LEN_W-1:0]            csr_capacity
);

   localparam int DEPTH = sle_pkg::DEPTH;
   localparam int LW = sle_pkg::LEN_W;
   localparam int DW = sle_pkg::DATA_W;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // control
   logic          state_ff, state_in;
   logic [LW-1:0] cap_ff, cap_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] step_ff, step_in;
   logic [LW-1:0] span_ff, span_in;     // occupied cells while rotating
   logic          hit_ff, hit_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // command held during a rotation
   logic [1:0]           cmd_ff, cmd_in;
   logic [LW-1:0]        pos_ff, pos_in;
   logic signed [DW-1:0] key_ff, key_in;
   logic signed [DW-1:0] grab_ff, grab_in;   // fetched or removed entry
   logic [LW-1:0]        found_ff, found_in;

   // result beat
   logic                 ok_ff, ok_in;
   logic signed [DW-1:0] rd_ff, rd_in;
   logic [LW-1:0]        fpos_ff, fpos_in;
   logic [LW-1:0]        cnt_ff, cnt_in;

   sle_pkg::cell_ctl_type ctl;
   logic signed [DW-1:0]  cell_q [DEPTH];
   logic signed [DW-1:0]  head;

   logic          take;
   logic          room;
   logic          pos_in_list;
   logic          pos_insertable;
   logic          last_step;
   logic          at_pos;
   logic          hit_now;
   logic [LW-1:0] pos_less;

   assign busy      = (state_ff == ST_RUN);
   assign take      = start && !busy;
   assign csr_ready = !busy;
   assign head      = cell_q[0];

   // free slot under min(capacity, DEPTH)
   assign room           = (len_ff < cap_ff) && (int'(len_ff) < DEPTH);
   assign pos_in_list    = (req_position != '0) && (req_position <= len_ff);
   assign pos_insertable = (req_position != '0) &&
                           ({1'b0, req_position} <= ({1'b0, len_ff} + 6'd1));
   assign pos_less       = req_position - 5'd1;

   assign last_step = (step_ff == len_ff - 5'd1);
   assign at_pos    = (step_ff == pos_ff - 5'd1);
   assign hit_now   = !hit_ff && (head == key_ff);

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      len_in       = len_ff;
      step_in      = step_ff;
      span_in      = span_ff;
      hit_in       = hit_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      grab_in      = grab_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      ok_in        = ok_ff;
      rd_in        = rd_ff;
      fpos_in      = fpos_ff;
      cnt_in       = cnt_ff;
      ctl.mode     = sle_pkg::CELL_HOLD;
      ctl.mark     = '0;
      ctl.span     = span_ff;

      if (csr_valid && csr_ready) begin
         cap_in = csr_capacity;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               // default: an immediate answer that leaves the list alone
               rsp_valid_in = 1'b1;
               ok_in        = 1'b0;
               rd_in        = '0;
               fpos_in      = '0;
               cnt_in       = len_ff;
               cmd_in       = req_command;
               pos_in       = req_position;
               key_in       = req_item_value;
               step_in      = '0;
               span_in      = len_ff;
               hit_in       = 1'b0;
               grab_in      = '0;
               found_in     = '0;
               case (req_command) inside
                  sle_pkg::CMD_INSERT: begin
                     if (pos_insertable && room) begin
                        ctl.mode = sle_pkg::CELL_INSERT;
                        ctl.mark = pos_less;
                        ctl.span = len_ff;
                        len_in   = len_ff + 5'd1;
                        ok_in    = 1'b1;
                        cnt_in   = len_ff + 5'd1;
                     end
                  end
                  sle_pkg::CMD_DELETE, sle_pkg::CMD_GET: begin
                     if (pos_in_list) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_RUN;
                     end
                  end
                  default: begin
                     if (len_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_RUN;
                     end
                  end
               endcase
            end
         end
         default: begin
            // one rotation step; the head cell holds entry number step_ff
            step_in  = step_ff + 5'd1;
            ctl.mode = sle_pkg::CELL_ROTATE;
            if (cmd_ff == sle_pkg::CMD_DELETE && at_pos) begin
               ctl.mode = sle_pkg::CELL_DROP;
               span_in  = span_ff - 5'd1;
               grab_in  = head;
            end else if (cmd_ff == sle_pkg::CMD_GET && at_pos) begin
               grab_in = head;
            end else if (cmd_ff == sle_pkg::CMD_LOCATE && hit_now) begin
               hit_in   = 1'b1;
               found_in = step_ff + 5'd1;
            end

            if (last_step) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               fpos_in      = '0;
               rd_in        = '0;
               cnt_in       = len_ff;
               if (cmd_ff == sle_pkg::CMD_LOCATE) begin
                  ok_in   = hit_in;
                  fpos_in = found_in;
               end else begin
                  ok_in = 1'b1;
                  rd_in = grab_in;
                  if (cmd_ff == sle_pkg::CMD_DELETE) begin
                     len_in = len_ff - 5'd1;
                     cnt_in = len_ff - 5'd1;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= sle_pkg::CAP_RESET;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         span_ff      <= '0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         span_ff      <= span_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      pos_ff   <= pos_in;
      key_ff   <= key_in;
      grab_ff  <= grab_in;
      found_ff <= found_in;
      ok_ff    <= ok_in;
      rd_ff    <= rd_in;
      fpos_ff  <= fpos_in;
      cnt_ff   <= cnt_in;
   end

   // row of cells: each sees its neighbours, the head and the insert value
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DW-1:0] prev_w;
      logic signed [DW-1:0] next_w;
      if (i == 0) begin : g_first
         assign prev_w = cell_q[i];
      end else begin : g_mid_prev
         assign prev_w = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_w = cell_q[i];
      end else begin : g_mid_next
         assign next_w = cell_q[i+1];
      end
      sle_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .ins_value  (req_item_value),
         .prev_value (prev_w),
         .next_value (next_w),
         .head_value (head),
         .cell_value (cell_q[i])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = ok_ff;
   assign rsp_read_value     = rd_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_entry_count    = cnt_ff;

endmodule

>>> rtl/sle_cell.sv
// sle_cell: one entry of the list, a 32-bit register fed from its neighbours, the head or the insert value.
// Depends on sle_pkg.
module sle_cell #(
   parameter int INDEX = 0
) (
   input  logic                                clock,
   input  sle_pkg::cell_ctl_type               ctl,
   input  logic signed [sle_pkg::DATA_W-1:0]   ins_value,
   input  logic signed [sle_pkg::DATA_W-1:0]   prev_value,
   input  logic signed [sle_pkg::DATA_W-1:0]   next_value,
   input  logic signed [sle_pkg::DATA_W-1:0]   head_value,
   output logic signed [sle_pkg::DATA_W-1:0]   cell_value
);

   logic signed [sle_pkg::DATA_W-1:0] data_ff;
   logic signed [sle_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctl.mode)
         sle_pkg::CELL_INSERT: begin
            if (INDEX == int'(ctl.mark)) begin
               data_in = ins_value;
            end else if (INDEX > int'(ctl.mark) && INDEX <= int'(ctl.span)) begin
               data_in = prev_value;
            end
         end
         sle_pkg::CELL_ROTATE: begin
            // last occupied cell wraps round to the head
            if (INDEX + 1 < int'(ctl.span)) begin
               data_in = next_value;
            end else if (INDEX + 1 == int'(ctl.span)) begin
               data_in = head_value;
            end
         end
         sle_pkg::CELL_DROP: begin
            if (INDEX + 1 < int'(ctl.span)) begin
               data_in = next_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign cell_value = data_ff;

endmodule
